### rtl/gamepad_teleop_conditioner_core_assert.svh
// Assertion macros for the gamepad teleop conditioner
`ifndef GAMEPAD_TELEOP_CONDITIONER_CORE_ASSERT_SVH
`define GAMEPAD_TELEOP_CONDITIONER_CORE_ASSERT_SVH
// check that a condition implies a consequence in the same cycle
`define GTC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// check that a condition implies a consequence in the next cycle
`define GTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/gtc_pkg.sv
// Shared types and constants for the gamepad teleop conditioner
`default_nettype none
package gtc_pkg;
  localparam int unsigned AxisW   = 16;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned OutW    = 17;
  localparam int unsigned LimW    = 16;
  localparam int unsigned DbW     = 14;
  localparam int unsigned CntW    = 5;
  localparam int unsigned BtnW    = 6;
  localparam int unsigned SelW    = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CfgIdxW-1:0] CFG_SPEED  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TURN   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEAD   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TAXIS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REST   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TORQUE = 3'd5;

  localparam logic signed [AxisW-1:0] HAT_PLUS  = 16'sd16384;
  localparam logic signed [AxisW-1:0] HAT_MINUS = -16'sd16384;

  // hat classes
  localparam logic [1:0] HAT_NONE = 2'd0;
  localparam logic [1:0] HAT_P    = 2'd1;
  localparam logic [1:0] HAT_M    = 2'd2;

  // front end sequencer
  typedef enum logic [1:0] {
    FR_IDLE, FR_TORQUE, FR_OFFER
  } fr_state_t;

  // back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE, BK_DZ, BK_DIV, BK_SCALE, BK_DONE
  } bk_state_t;

  // classified request from front to back
  typedef struct packed {
    logic                     brake;
    logic                     fwd_ok;
    logic                     side_ok;
    logic                     turn_ok;
    logic signed [AxisW-1:0]  fwd;
    logic signed [AxisW-1:0]  side;
    logic signed [AxisW-1:0]  turn;
    logic [3:0]               rest_out;
    logic [3:0]               hip;
    logic signed [OutW-1:0]   torque;
  } gtc_req_t;
endpackage
`default_nettype wire

### rtl/gtc_if.sv
// Valid/ready channel interface
`default_nettype none
interface gtc_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/gamepad_teleop_conditioner_core.sv
// Top level of the gamepad teleop conditioner
`default_nettype none
// One sample in, one result out. The front end updates button, hat and torque
// state (a braking sample leaves hat and torque state alone and skips the torque
// multiply); the back end runs the three axis deadzones through one shared
// one-bit-per-cycle divider and one scaling multiplier, each axis taking setup,
// 15 divide steps and scale. The back end takes a new sample only when idle with
// its output register empty. Front and back overlap through a two-entry queue;
// the output register holds a result until it is taken, and while it waits the
// front end and queue still take up to three more samples.
module gamepad_teleop_conditioner_core #(
  parameter int unsigned AXIS_SLOTS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire logic signed [15:0] in_axis_0,
  input  wire logic signed [15:0] in_axis_1,
  input  wire logic signed [15:0] in_axis_2,
  input  wire logic signed [15:0] in_axis_3,
  input  wire logic signed [15:0] in_axis_4,
  input  wire logic signed [15:0] in_axis_5,
  input  wire logic signed [15:0] in_axis_6,
  input  wire logic signed [15:0] in_axis_7,
  input  wire logic [4:0] in_axis_count,
  input  wire logic [5:0] in_button_bits,
  input  wire logic [4:0] in_button_count,
  output      logic out_valid,
  input  wire logic out_ready,
  output      logic signed [16:0] out_forward_speed,
  output      logic signed [16:0] out_side_speed,
  output      logic signed [16:0] out_turn_rate,
  output      logic out_brake_active,
  output      logic [3:0] out_rest_mask,
  output      logic [3:0] out_hip_mask,
  output      logic signed [16:0] out_hip_torque,
  input  wire logic cfg_we,
  input  wire logic [gtc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [gtc_pkg::CfgDatW-1:0] cfg_data
);
  import gtc_pkg::*;
  `include "gamepad_teleop_conditioner_core_assert.svh"

  logic [LimW-1:0] speed_r, turn_r, torque_r;
  logic [DbW-1:0] db_r;
  logic [SelW-1:0] tax_r;
  logic rest_en_r;
  logic signed [AxisW-1:0] axis [AXIS_SLOTS];
  logic fq_valid, fq_ready, bq_valid, bq_ready;
  gtc_req_t fq_data, bq_data;

  // slots past eight never drive anything
  always_comb begin
    for (int i = 0; i < AXIS_SLOTS; i++) axis[i] = '0;
    axis[0] = in_axis_0; axis[1] = in_axis_1; axis[2] = in_axis_2; axis[3] = in_axis_3;
    axis[4] = in_axis_4; axis[5] = in_axis_5; axis[6] = in_axis_6; axis[7] = in_axis_7;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= 16'd3277; turn_r <= 16'd6144; db_r <= 14'd2458;
      tax_r <= 3'd2; rest_en_r <= 1'b0; torque_r <= 16'd2560;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED:  speed_r <= cfg_data;
        CFG_TURN:   turn_r <= cfg_data;
        CFG_DEAD:   db_r <= cfg_data[DbW-1:0];
        CFG_TAXIS:  tax_r <= cfg_data[SelW-1:0];
        CFG_REST:   rest_en_r <= cfg_data[0];
        CFG_TORQUE: torque_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gtc_front #(.AXIS_SLOTS(AXIS_SLOTS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .axis,
    .axis_count(in_axis_count), .button_bits(in_button_bits),
    .button_count(in_button_count), .turn_axis_index(tax_r),
    .rest_en(rest_en_r), .torque_limit(torque_r),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  gtc_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
  );

  gtc_back u_back (
    .clk, .rst_n, .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .dead_band(db_r), .speed_limit(speed_r), .turn_limit(turn_r),
    .o_valid(out_valid), .o_ready(out_ready),
    .o_fwd(out_forward_speed), .o_side(out_side_speed), .o_turn(out_turn_rate),
    .o_brake(out_brake_active), .o_rest(out_rest_mask), .o_hip(out_hip_mask),
    .o_torque(out_hip_torque)
  );

  `GTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `GTC_ASSERT_IMPL(a_rest_off, out_valid && !rest_en_r, out_rest_mask == 4'd0,
                   "rest mask shown while disabled")
  `GTC_ASSERT_IMPL(a_brake_zero, out_valid && out_brake_active,
                   out_forward_speed == 17'sd0, "motion while braking")
endmodule
`default_nettype wire

### rtl/gtc_front.sv
// Front end: accept samples, update button, hat and torque state, classify axes
`default_nettype none
module gtc_front #(
  parameter int unsigned AXIS_SLOTS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic signed [gtc_pkg::AxisW-1:0]   axis [AXIS_SLOTS],
  input  wire logic [gtc_pkg::CntW-1:0]           axis_count,
  input  wire logic [gtc_pkg::BtnW-1:0]           button_bits,
  input  wire logic [gtc_pkg::CntW-1:0]           button_count,
  input  wire logic [gtc_pkg::SelW-1:0]           turn_axis_index,
  input  wire logic                               rest_en,
  input  wire logic [gtc_pkg::LimW-1:0]           torque_limit,
  output      logic                               q_valid,
  input  wire logic                               q_ready,
  output      gtc_pkg::gtc_req_t                  q_data
);
  import gtc_pkg::*;
  localparam int unsigned SlotCntW = $clog2(AXIS_SLOTS + 1);

  logic [3:0] rest_r, rest_nxt, lastb_r, lastb_nxt, hip_r, hip_nxt;
  logic [1:0] vhat_r, vhat_nxt, hhat_r, hhat_nxt;
  logic       busy_r, busy_nxt;
  fr_state_t  state_r, state_nxt;
  logic signed [OutW-1:0] tq_r, tq_nxt;
  // torque multiply stage
  logic signed [18:0] tdiff_r;
  logic [LimW-1:0] tlim_r;
  gtc_req_t req_r, req_nxt;
  logic [5:0] pressed;
  logic [SlotCntW-1:0] cnt;
  logic brake;
  logic [1:0] vc, hc;
  logic [3:0] tog;
  logic signed [AxisW:0] p, n;
  logic signed [35:0] tprod;
  logic signed [20:0] tq_div;
  logic accept;

  assign in_ready = !busy_r;
  assign accept = in_valid && in_ready;
  assign q_valid = busy_r && (state_r == FR_OFFER);

  // present the request with the state its sample left behind
  always_comb begin
    q_data = req_r;
    q_data.rest_out = rest_en ? rest_r : 4'd0;
    q_data.hip = hip_r;
    q_data.torque = tq_r;
  end

  function automatic logic [1:0] hat_cls(input logic signed [AxisW-1:0] v);
    if (v == HAT_PLUS) return HAT_P;
    if (v == HAT_MINUS) return HAT_M;
    return HAT_NONE;
  endfunction

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pressed[i] = button_bits[i] && (CntW'(i) < button_count);
    end
    cnt = (axis_count > CntW'(AXIS_SLOTS)) ? SlotCntW'(AXIS_SLOTS) : SlotCntW'(axis_count);
    brake = pressed[4] && pressed[5];
    vc = hat_cls(axis[7]);
    hc = hat_cls(axis[6]);
    tog = 4'd0;
    if (cnt > SlotCntW'(7)) begin
      if (vc == HAT_P && vhat_r != HAT_P) tog = tog ^ 4'h1;
      if (vc == HAT_M && vhat_r != HAT_M) tog = tog ^ 4'h4;
    end
    if (cnt > SlotCntW'(6)) begin
      if (hc == HAT_P && hhat_r != HAT_P) tog = tog ^ 4'h8;
      if (hc == HAT_M && hhat_r != HAT_M) tog = tog ^ 4'h2;
    end
    p = (cnt > SlotCntW'(4)) ? (17'sd16384 - 17'(axis[4])) : 17'sd0;
    n = (cnt > SlotCntW'(3)) ? (17'sd16384 - 17'(axis[3])) : 17'sd0;
    tprod = 36'(tdiff_r) * $signed({1'b0, tlim_r});
    // truncate toward zero on divide by 32768
    tq_div = 21'((tprod + ((tprod < 0) ? 36'sd32767 : 36'sd0)) >>> 15);
  end

  // sequence: capture, torque (skipped on brake), offer to the queue
  always_comb begin
    state_nxt = state_r;
    if (accept) state_nxt = brake ? FR_OFFER : FR_TORQUE;
    else if (busy_r && state_r == FR_TORQUE) state_nxt = FR_OFFER;
    else if (q_valid && q_ready) state_nxt = FR_IDLE;
  end

  // sample capture, state update, torque multiply
  always_comb begin
    rest_nxt = rest_r; lastb_nxt = lastb_r; hip_nxt = hip_r;
    vhat_nxt = vhat_r; hhat_nxt = hhat_r; tq_nxt = tq_r;
    busy_nxt = busy_r; req_nxt = req_r;
    if (accept) begin
      busy_nxt = 1'b1;
      if (rest_en) begin
        rest_nxt = rest_r ^ (pressed[3:0] & ~lastb_r);
        lastb_nxt = pressed[3:0];
      end
      req_nxt.brake = brake;
      req_nxt.fwd_ok = cnt > SlotCntW'(1);
      req_nxt.side_ok = cnt > SlotCntW'(0);
      req_nxt.turn_ok = cnt > SlotCntW'(turn_axis_index);
      req_nxt.fwd = axis[1];
      req_nxt.side = axis[0];
      req_nxt.turn = axis[turn_axis_index];
      if (!brake) begin
        hip_nxt = hip_r ^ tog;
        if (cnt > SlotCntW'(7)) vhat_nxt = vc;
        if (cnt > SlotCntW'(6)) hhat_nxt = hc;
      end
    end else if (busy_r && state_r == FR_TORQUE) begin
      if (tq_div > 21'sd65535) tq_nxt = 17'sd65535;
      else if (tq_div < -21'sd65535) tq_nxt = -17'sd65535;
      else tq_nxt = OutW'(tq_div);
    end else if (q_valid && q_ready) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tdiff_r <= 19'(p) - 19'(n);
      tlim_r <= torque_limit;
    end
    if (!rst_n) begin
      rest_r <= '0; lastb_r <= '0; hip_r <= '0; vhat_r <= HAT_NONE;
      hhat_r <= HAT_NONE; tq_r <= '0; busy_r <= 1'b0; state_r <= FR_IDLE;
      req_r <= '0;
    end else begin
      rest_r <= rest_nxt; lastb_r <= lastb_nxt; hip_r <= hip_nxt;
      vhat_r <= vhat_nxt; hhat_r <= hhat_nxt; tq_r <= tq_nxt;
      busy_r <= busy_nxt; state_r <= state_nxt; req_r <= req_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/gtc_queue.sv
// Two-entry request queue between front and back
`default_nettype none
module gtc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_valid,
  output      logic               wr_ready,
  input  wire gtc_pkg::gtc_req_t  wr_data,
  output      logic               rd_valid,
  input  wire logic               rd_ready,
  output      gtc_pkg::gtc_req_t  rd_data
);
  import gtc_pkg::*;
  gtc_req_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // push and pop
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

### rtl/gtc_back.sv
// Back end: deadzone with shared serial divider, limit scaling, output register
`default_nettype none
module gtc_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_valid,
  output      logic                     q_ready,
  input  wire gtc_pkg::gtc_req_t        q_data,
  input  wire logic [gtc_pkg::DbW-1:0]  dead_band,
  input  wire logic [gtc_pkg::LimW-1:0] speed_limit,
  input  wire logic [gtc_pkg::LimW-1:0] turn_limit,
  output      logic                     o_valid,
  input  wire logic                     o_ready,
  output      logic signed [gtc_pkg::OutW-1:0] o_fwd,
  output      logic signed [gtc_pkg::OutW-1:0] o_side,
  output      logic signed [gtc_pkg::OutW-1:0] o_turn,
  output      logic                     o_brake,
  output      logic [3:0]               o_rest,
  output      logic [3:0]               o_hip,
  output      logic signed [gtc_pkg::OutW-1:0] o_torque
);
  import gtc_pkg::*;

  bk_state_t st_r, st_nxt;
  gtc_req_t req_r;
  logic signed [LevelW-1:0] lvl_r [3];
  logic [1:0] ax_r;
  logic [4:0] bit_r;
  logic [28:0] rem_r;
  logic [14:0] quo_r;
  logic [14:0] den_r;
  logic neg_r, zero_r;
  logic signed [AxisW-1:0] cur_v;
  logic cur_ok;
  logic [15:0] mag;
  logic [14:0] den_c;
  logic [15:0] num;
  logic signed [33:0] prod;
  logic signed [OutW-1:0] sc;
  logic out_full_r;

  assign q_ready = (st_r == BK_IDLE) && !out_full_r;
  assign o_valid = out_full_r;

  always_comb begin
    case (ax_r)
      2'd0: begin cur_v = req_r.fwd; cur_ok = req_r.fwd_ok; end
      2'd1: begin cur_v = req_r.side; cur_ok = req_r.side_ok; end
      default: begin cur_v = req_r.turn; cur_ok = 1'b1; end
    endcase
    mag = cur_v[AxisW-1] ? 16'(-cur_v) : 16'(cur_v);
    den_c = 15'd16384 - 15'(dead_band);
    // cap the numerator at the divisor, where the level saturates anyway
    num = (mag - 16'(dead_band) > 16'(den_c)) ? 16'(den_c) : mag - 16'(dead_band);
    prod = 34'(lvl_r[ax_r]) * $signed({1'b0, (ax_r == 2'd2) ? turn_limit : speed_limit});
    sc = OutW'((prod + ((prod < 0) ? 34'sd16383 : 34'sd0)) >>> 14);
  end

  function automatic logic [28:0] trial_sub(input logic [28:0] r, input logic [14:0] d);
    logic [28:0] s;
    s = r - ({14'd0, d} << 14);
    return {s[27:0], 1'b0};
  endfunction

  function automatic logic signed [LevelW-1:0] dz_final();
    logic [14:0] q;
    logic signed [LevelW-1:0] m;
    q = quo_r;
    if (rem_r[28:14] >= den_r) q[0] = 1'b1;
    if (zero_r) m = '0;
    else m = (q > 15'd16384) ? 16'sd16384 : 16'(q);
    return neg_r ? -m : m;
  endfunction

  // sequencer: three axes, each deadzone (15 step divide) then scale
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (q_valid && q_ready) st_nxt = BK_DZ;
      BK_DZ:    st_nxt = BK_DIV;
      BK_DIV:   if (bit_r == 5'd0) st_nxt = BK_SCALE;
      BK_SCALE: st_nxt = (ax_r == 2'd2) ? BK_DONE : BK_DZ;
      BK_DONE:  st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: begin
        if (q_valid && q_ready) begin
          req_r <= q_data;
          ax_r <= 2'd0;
        end
      end
      BK_DZ: begin
        neg_r <= cur_v[AxisW-1];
        zero_r <= ({1'b0, mag} <= {3'b0, dead_band});
        rem_r <= 29'(num) << 14;
        den_r <= den_c;
        quo_r <= '0;
        bit_r <= 5'd14;
      end
      BK_DIV: begin
        // restoring divide, one quotient bit per cycle, from the top
        if (rem_r[28:14] >= den_r) begin
          quo_r[bit_r[3:0]] <= 1'b1;
          rem_r <= trial_sub(rem_r, den_r);
        end else begin
          rem_r <= {rem_r[27:0], 1'b0};
        end
        if (bit_r != 5'd0) bit_r <= bit_r - 5'd1;
      end
      BK_SCALE: begin
        ax_r <= ax_r + 2'd1;
      end
      default: ;
    endcase
  end

  // level registers and output register
  always_ff @(posedge clk) begin
    if (st_r == BK_SCALE) begin
      case (ax_r)
        2'd0: o_fwd <= sc;
        2'd1: o_side <= sc;
        default: o_turn <= sc;
      endcase
    end
    if (st_r == BK_DONE) begin
      o_brake <= req_r.brake;
      o_rest <= req_r.rest_out;
      o_hip <= req_r.hip;
      o_torque <= req_r.torque;
    end
    if (!rst_n) begin
      st_r <= BK_IDLE;
      out_full_r <= 1'b0;
      for (int i = 0; i < 3; i++) lvl_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_DONE) out_full_r <= 1'b1;
      else if (o_valid && o_ready) out_full_r <= 1'b0;
      // settle the level after the divide finishes
      if (st_r == BK_DIV && bit_r == 5'd0) begin
        if (req_r.brake) lvl_r[ax_r] <= '0;
        else if (cur_ok) lvl_r[ax_r] <= (ax_r == 2'd2 && !req_r.turn_ok) ? '0 : dz_final();
        else if (ax_r == 2'd2) lvl_r[ax_r] <= '0;
      end
    end
  end
endmodule
`default_nettype wire

### tb/gamepad_teleop_conditioner_core_test.sv
// Self-checking testbench for the gamepad teleop conditioner core
`default_nettype none
module gamepad_teleop_conditioner_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gtc_pkg::*;

  typedef struct packed {
    logic [7:0][15:0] axis;
    logic [4:0]       axis_count;
    logic [5:0]       button_bits;
    logic [4:0]       button_count;
  } sample_t;

  typedef struct packed {
    logic signed [16:0] forward_speed;
    logic signed [16:0] side_speed;
    logic signed [16:0] turn_rate;
    logic               brake_active;
    logic [3:0]         rest_mask;
    logic [3:0]         hip_mask;
    logic signed [16:0] hip_torque;
  } command_t;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 100;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDatW-1:0] cfg_data;

  gtc_if #(.T(sample_t))  sample_ch (clk);
  gtc_if #(.T(command_t)) command_ch (clk);

  gamepad_teleop_conditioner_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (sample_ch.valid),
    .in_ready         (sample_ch.ready),
    .in_axis_0        (sample_ch.data.axis[0]),
    .in_axis_1        (sample_ch.data.axis[1]),
    .in_axis_2        (sample_ch.data.axis[2]),
    .in_axis_3        (sample_ch.data.axis[3]),
    .in_axis_4        (sample_ch.data.axis[4]),
    .in_axis_5        (sample_ch.data.axis[5]),
    .in_axis_6        (sample_ch.data.axis[6]),
    .in_axis_7        (sample_ch.data.axis[7]),
    .in_axis_count    (sample_ch.data.axis_count),
    .in_button_bits   (sample_ch.data.button_bits),
    .in_button_count  (sample_ch.data.button_count),
    .out_valid        (command_ch.valid),
    .out_ready        (command_ch.ready),
    .out_forward_speed(command_ch.data.forward_speed),
    .out_side_speed   (command_ch.data.side_speed),
    .out_turn_rate    (command_ch.data.turn_rate),
    .out_brake_active (command_ch.data.brake_active),
    .out_rest_mask    (command_ch.data.rest_mask),
    .out_hip_mask     (command_ch.data.hip_mask),
    .out_hip_torque   (command_ch.data.hip_torque),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // conditioner settings as the block should hold them
  int unsigned speed_lim, turn_lim, db_width, turn_sel, rest_en, torque_lim;
  // conditioner state mirror
  int fwd_lvl, side_lvl, turn_lvl, torque_lvl;
  logic brake_q;
  logic [3:0] rest_q, btn_last, hip_q;
  logic [1:0] vhat_last, hhat_last;

  command_t pending_commands[$];
  int errors;
  int unsigned idle_pct, stall_pct;
  longint unsigned cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("gamepad_teleop_conditioner_core_test: errors");
      $finish;
    end
  end

  // random backpressure on the command side
  always @(posedge clk) begin
    command_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each command against the oldest prediction
  always @(posedge clk) begin
    command_t want;
    if (rst_n && command_ch.valid && command_ch.ready) begin
      if (pending_commands.size() == 0) begin
        $display("%0t unexpected command: got %p", $time, command_ch.data);
        errors++;
      end else begin
        want = pending_commands.pop_front();
        if (want.forward_speed !== command_ch.data.forward_speed) begin
          $display("%0t forward_speed exp %0d got %0d", $time, want.forward_speed,
                   command_ch.data.forward_speed);
          errors++;
        end
        if (want.side_speed !== command_ch.data.side_speed) begin
          $display("%0t side_speed exp %0d got %0d", $time, want.side_speed,
                   command_ch.data.side_speed);
          errors++;
        end
        if (want.turn_rate !== command_ch.data.turn_rate) begin
          $display("%0t turn_rate exp %0d got %0d", $time, want.turn_rate,
                   command_ch.data.turn_rate);
          errors++;
        end
        if (want.brake_active !== command_ch.data.brake_active) begin
          $display("%0t brake_active exp %0d got %0d", $time, want.brake_active,
                   command_ch.data.brake_active);
          errors++;
        end
        if (want.rest_mask !== command_ch.data.rest_mask) begin
          $display("%0t rest_mask exp %h got %h", $time, want.rest_mask,
                   command_ch.data.rest_mask);
          errors++;
        end
        if (want.hip_mask !== command_ch.data.hip_mask) begin
          $display("%0t hip_mask exp %h got %h", $time, want.hip_mask,
                   command_ch.data.hip_mask);
          errors++;
        end
        if (want.hip_torque !== command_ch.data.hip_torque) begin
          $display("%0t hip_torque exp %0d got %0d", $time, want.hip_torque,
                   command_ch.data.hip_torque);
          errors++;
        end
      end
    end
  end

  // rescaling deadzone, quotient truncated toward zero
  function automatic int deadzone_level(logic signed [15:0] v);
    longint mag, q;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    if (mag <= db_width) return 0;
    q = ((mag - db_width) * 16384) / (16384 - db_width);
    if (q > 16384) q = 16384;
    return (v > 0) ? int'(q) : -int'(q);
  endfunction

  function automatic logic [1:0] hat_class(logic signed [15:0] v);
    if (v == HAT_PLUS) return HAT_P;
    if (v == HAT_MINUS) return HAT_M;
    return HAT_NONE;
  endfunction

  function automatic logic signed [16:0] scale_level(int lvl, int unsigned lim);
    longint p;
    p = (longint'(lvl) * longint'(lim)) / 16384;
    return p[16:0];
  endfunction

  // advance the state mirror by one sample and form its command
  function automatic command_t condition_sample(sample_t s);
    int unsigned cnt;
    logic [5:0] pressed;
    logic [1:0] c;
    longint p, n, t;
    command_t r;
    cnt = (s.axis_count > 8) ? 8 : s.axis_count;
    pressed = '0;
    for (int i = 0; i < 6; i++) begin
      if (i < s.button_count && s.button_bits[i]) pressed[i] = 1'b1;
    end
    if (rest_en != 0) begin
      rest_q ^= pressed[3:0] & ~btn_last;
      btn_last = pressed[3:0];
    end
    brake_q = pressed[5] && pressed[4];
    if (brake_q) begin
      fwd_lvl = 0;
      side_lvl = 0;
      turn_lvl = 0;
    end else begin
      if (cnt > 1) fwd_lvl = deadzone_level(s.axis[1]);
      if (cnt > 0) side_lvl = deadzone_level(s.axis[0]);
      turn_lvl = (cnt > turn_sel) ? deadzone_level(s.axis[turn_sel]) : 0;
      // vertical hat: plus toggles A, minus toggles C
      if (cnt > 7) begin
        c = hat_class(s.axis[7]);
        if (c == HAT_P && vhat_last != HAT_P) hip_q ^= 4'h1;
        if (c == HAT_M && vhat_last != HAT_M) hip_q ^= 4'h4;
        vhat_last = c;
      end
      // horizontal hat: plus toggles D, minus toggles B
      if (cnt > 6) begin
        c = hat_class(s.axis[6]);
        if (c == HAT_P && hhat_last != HAT_P) hip_q ^= 4'h8;
        if (c == HAT_M && hhat_last != HAT_M) hip_q ^= 4'h2;
        hhat_last = c;
      end
      p = (cnt > 4) ? 16384 - longint'($signed(s.axis[4])) : 0;
      n = (cnt > 3) ? 16384 - longint'($signed(s.axis[3])) : 0;
      t = ((p - n) * longint'(torque_lim)) / 32768;
      if (t > 65535) t = 65535;
      if (t < -65535) t = -65535;
      torque_lvl = int'(t);
    end
    r.forward_speed = scale_level(fwd_lvl, speed_lim);
    r.side_speed    = scale_level(side_lvl, speed_lim);
    r.turn_rate     = scale_level(turn_lvl, turn_lim);
    r.brake_active  = brake_q;
    r.rest_mask     = (rest_en != 0) ? rest_q : 4'h0;
    r.hip_mask      = hip_q;
    r.hip_torque    = torque_lvl[16:0];
    return r;
  endfunction

  // hold one request until taken, then record its prediction
  task automatic send_sample(sample_t s);
    sample_ch.valid <= 1'b1;
    sample_ch.data <= s;
    do @(posedge clk); while (!sample_ch.ready);
    pending_commands.push_back(condition_sample(s));
    if ($urandom_range(99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // drop valid and wait for the block to empty
  task automatic drain;
    sample_ch.valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // drive one register write for one cycle; the caller drops the enable
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    case (idx)
      CFG_SPEED:  speed_lim  = val & 16'hFFFF;
      CFG_TURN:   turn_lim   = val & 16'hFFFF;
      CFG_DEAD:   db_width   = val & 14'h3FFF;
      CFG_TAXIS:  turn_sel   = val & 3'h7;
      CFG_REST:   rest_en    = val & 1'b1;
      CFG_TORQUE: torque_lim = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned sp, int unsigned tu, int unsigned db,
                           int unsigned ta, int unsigned re, int unsigned tq);
    write_reg(CFG_SPEED, sp);
    write_reg(CFG_TURN, tu);
    write_reg(CFG_DEAD, db);
    write_reg(CFG_TAXIS, ta);
    write_reg(CFG_REST, re);
    write_reg(CFG_TORQUE, tq);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_axis();
    int v;
    case ($urandom_range(7))
      0: v = 16384;
      1: v = -16384;
      2: v = 0;
      3: v = int'(db_width) + $urandom_range(2) - 1;
      4: v = -(int'(db_width) + $urandom_range(2) - 1);
      default: v = $urandom_range(32768) - 16384;
    endcase
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_hat();
    case ($urandom_range(3))
      0: return HAT_PLUS;
      1: return HAT_MINUS;
      2: return 16'd0;
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  // mostly full samples with random content, some with short counts
  function automatic sample_t pick_sample();
    sample_t s;
    for (int i = 0; i < 6; i++) s.axis[i] = pick_axis();
    s.axis[6] = pick_hat();
    s.axis[7] = pick_hat();
    if ($urandom_range(99) < 80) begin
      s.axis_count = 5'($urandom_range(16, 8));
      s.button_count = 5'($urandom_range(16, 6));
      s.button_bits = ($urandom_range(3) == 0) ? (6'h30 | 6'($urandom_range(15)))
                                               : 6'($urandom_range(63));
    end else begin
      s.axis_count = 5'($urandom_range(16));
      s.button_count = 5'($urandom_range(16));
      s.button_bits = 6'($urandom_range(63));
    end
    return s;
  endfunction

  function automatic sample_t make_sample(int a0, int a1, int a2, int a3, int a4,
                                          int a6, int a7, int cnt, int btn, int bcnt);
    sample_t s;
    s.axis[0] = a0[15:0];
    s.axis[1] = a1[15:0];
    s.axis[2] = a2[15:0];
    s.axis[3] = a3[15:0];
    s.axis[4] = a4[15:0];
    s.axis[5] = 16'd0;
    s.axis[6] = a6[15:0];
    s.axis[7] = a7[15:0];
    s.axis_count = cnt[4:0];
    s.button_bits = btn[5:0];
    s.button_count = bcnt[4:0];
    return s;
  endfunction

  // reset settings with stick, hat, trigger and brake corners
  task automatic test_reset_settings;
    send_sample(make_sample(0, 0, 0, 16384, 16384, 0, 0, 8, 0, 6));
    send_sample(make_sample(16384, -16384, 16384, -16384, 16384, 16384, -16384, 8, 0, 6));
    send_sample(make_sample(2458, 2459, -2459, 16384, -16384, 16384, -16384, 8, 0, 6));
    send_sample(make_sample(-2458, 20, 16383, -16384, -16384, -16384, 16384, 16, 0, 16));
    send_sample(make_sample(9000, 9000, 9000, 0, 0, 0, 0, 8, 6'h30, 6));
    send_sample(make_sample(9000, 9000, 9000, 0, 0, 16384, 16384, 8, 6'h30, 5));
    send_sample(make_sample(-9000, 5000, 5000, 0, 0, 16384, 16384, 2, 6'h3F, 16));
    send_sample(make_sample(7000, 7000, 7000, 100, 100, 0, 0, 0, 6'h3F, 0));
    send_sample(make_sample(7000, -7000, 7000, 100, -300, 0, 0, 4, 0, 0));
    drain();
  endtask

  // rest toggling, turn axis choice and saturation at the extremes
  task automatic test_extreme_settings;
    write_all(65535, 65535, 0, 7, 1, 65535);
    send_sample(make_sample(16384, -16384, 0, 16384, -16384, 0, -16384, 8, 6'h0F, 4));
    send_sample(make_sample(-1, 1, 0, -16384, 16384, 0, -16384, 8, 6'h00, 4));
    send_sample(make_sample(-16384, 16384, 0, 0, 0, 0, 16384, 8, 6'h05, 6));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 16384, 7, 6'h3A, 6));
    drain();
    write_all(0, 0, 16383, 5, 1, 0);
    send_sample(make_sample(16384, 16383, -16384, 16384, -16384, 16384, 0, 8, 6'h0F, 16));
    send_sample(make_sample(-16384, -16383, 0, 0, 0, 0, 0, 6, 6'h03, 16));
    drain();
    write_all(3277, 6144, 16383, 2, 0, 2560);
    send_sample(make_sample(16384, -16384, 16384, 0, 0, 0, 0, 8, 6'h0F, 6));
    send_sample(make_sample(16383, -16383, 0, 0, 0, 0, 0, 8, 0, 6));
    drain();
  endtask

  // random samples over several settings and idling and stall mixes
  task automatic test_random_traffic;
    int unsigned idle_set[4] = '{0, 45, 0, 34};
    int unsigned stall_set[4] = '{0, 0, 45, 34};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_all(65535, 65535, 0, 0, 1, 65535);
        1: write_all(0, 1, 16383, 7, 0, 0);
        2: write_all($urandom_range(65535), $urandom_range(65535), $urandom_range(4000),
                     $urandom_range(7), 1, $urandom_range(65535));
        default: write_all($urandom_range(65535), $urandom_range(65535),
                           $urandom_range(16383), $urandom_range(7), $urandom_range(1),
                           $urandom_range(65535));
      endcase
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      repeat (220) send_sample(pick_sample());
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    command_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycle_count = 0;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    speed_lim = 3277;
    turn_lim = 6144;
    db_width = 2458;
    turn_sel = 2;
    rest_en = 0;
    torque_lim = 2560;
    fwd_lvl = 0;
    side_lvl = 0;
    turn_lvl = 0;
    torque_lvl = 0;
    brake_q = 1'b0;
    rest_q = '0;
    btn_last = '0;
    hip_q = '0;
    vhat_last = HAT_NONE;
    hhat_last = HAT_NONE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_extreme_settings();
    test_random_traffic();
    drain();
    if (errors == 0) begin
      $display("gamepad_teleop_conditioner_core_test: clean");
    end else begin
      $display("gamepad_teleop_conditioner_core_test: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
